// File: rtl/ntc_avg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC average Steinhart-Hart package
// Shared widths, constants and register indexes of the thermistor core.
// ----------------------------------------------------------------------------
package ntc_avg_pkg;

    localparam int SAMPLES_DEF = 10;

    localparam int ADC_W   = 10;
    localparam int SUM_W   = 14;
    localparam int CNT_W   = 4;
    localparam int SER_W   = 20;
    localparam int COEF_W  = 48;
    localparam int TEMP_W  = 16;
    localparam int CFG_IDX_W = 2;

    // log2 fraction bits and ln 2 in the same scale
    localparam int            LOG_FRAC = 24;
    localparam logic [63:0]   LN2_Q24  = 64'd11629080;
    localparam logic [9:0]    ADC_FULL = 10'd1023;
    localparam logic [31:0]   LOG_K    = 32'd1000;
    localparam logic [48:0]   KELVIN_CENTI = 49'd27315;

    // divider: dividend of 100 * 2^40 needs 47 bits
    localparam int            DIV_W    = 47;

    localparam logic [SER_W-1:0]  SERIES_RST = 20'd9700;
    localparam logic [COEF_W-1:0] COEF_A_RST = 48'd2464333213;
    localparam logic [COEF_W-1:0] COEF_B_RST = 48'd245440682;
    localparam logic [COEF_W-1:0] COEF_C_RST = 48'd599234;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERIES  = 2'd0,
        CFG_COEFF_A = 2'd1,
        CFG_COEFF_B = 2'd2,
        CFG_COEFF_C = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [47:0] ma;
        logic [47:0] mb;
        logic        neg;
    } t_mul_op;

endpackage

// File: rtl/ntc_average_steinhart_hart_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC thermistor window average and Steinhart-Hart temperature core
// Averages converter samples and converts the average to hundredths of degC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_adc_sample) takes one sample
//   per transaction. Every sample but the last of a window is taken without
//   a stall. The closing sample of a window starts the conversion and
//   o_in_stall stays high until it finishes. It runs three logarithms, each
//   a normalizing shift and then 24 squaring rounds on the shared 48x16
//   multiplier, then six products and a 47-step restoring divide by 1/T.
//   A rail average or a zero series resistor goes straight to the final
//   step; a nonpositive 1/T skips the divide. The window average is a
//   reciprocal multiply.
//   Output channel (o_out_valid / i_out_stall) carries temperature, fault
//   and average, valid in the same cycle that o_in_stall drops. The
//   result sits in an output register; the core takes the next samples
//   while it waits, and holds in its final step only if a new result is
//   ready and the old one is still stalled.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are registered
//   directly and are meant for idle periods only.
//   Reset (synchronous, active low) restores default coefficients, clears
//   the window and drops any pending result.
// ----------------------------------------------------------------------------
module ntc_average_steinhart_hart_core #(
    parameter int SAMPLES = ntc_avg_pkg::SAMPLES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [ntc_avg_pkg::ADC_W-1:0]          i_adc_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [ntc_avg_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic                                   o_fault,
    output logic [ntc_avg_pkg::ADC_W-1:0]          o_average_code,
    input  logic                                   i_cfg_we,
    input  logic [ntc_avg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ntc_avg_pkg::COEF_W-1:0]         i_cfg_data
);
    import ntc_avg_pkg::*;

    localparam logic [CNT_W:0] SAMPLES_W = (CNT_W+1)'(SAMPLES);

    // sum / SAMPLES as (sum * ceil(2^18 / SAMPLES)) >> 18, exact for 14-bit sums
    localparam int                  AVG_SHIFT = 18;
    localparam logic [AVG_SHIFT:0]  AVG_RECIP =
        (AVG_SHIFT+1)'(((1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_AVG, ST_NUM, ST_LNORM, ST_LSQ, ST_LNR, ST_SQ,
        ST_CUBE, ST_PB, ST_PC, ST_TDIV, ST_DONE
    } t_state;

    function automatic logic [47:0] abs48(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        return m[47:0];
    endfunction

    function automatic t_mul_op mk_mul(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
        t_mul_op op;
        op.ma  = abs48(a);
        op.mb  = abs48(b);
        op.neg = a[63] ^ b[63];
        return op;
    endfunction

    t_state r_state, n_state;
    logic [SER_W-1:0]        r_series;
    logic [COEF_W-1:0]       r_coeff_a, r_coeff_b, r_coeff_c;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ADC_W-1:0]        r_avg, n_avg;
    logic [47:0]             r_ma, n_ma, r_mb, n_mb;
    logic [95:0]             r_acc, n_acc;
    logic [1:0]              r_mcnt, n_mcnt;
    logic                    r_neg, n_neg;
    logic [31:0]             r_m, n_m;
    logic [4:0]              r_msb, n_msb, r_lbit, n_lbit;
    logic [LOG_FRAC-1:0]     r_frac, n_frac;
    logic [1:0]              r_lsel, n_lsel;
    logic signed [63:0]      r_lq, n_lq, r_lnr, n_lnr, r_tmp, n_tmp, r_p1, n_p1;
    logic [63:0]             r_dvs, n_dvs, r_rem, n_rem;
    logic [DIV_W-1:0]        r_dvd, n_dvd, r_quo, n_quo;
    logic [5:0]              r_dcnt, n_dcnt;
    logic signed [TEMP_W-1:0] r_temp, n_temp;
    logic                    r_fault, n_fault;
    logic                    r_out_valid, n_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp, n_out_temp;
    logic                    r_out_fault, n_out_fault;
    logic [ADC_W-1:0]        r_out_avg, n_out_avg;

    // shared multiplier and divider datapath
    logic [15:0]        m_chunk;
    logic [63:0]        m_part;
    logic [95:0]        m_sum;
    logic [63:0]        m_mag;
    logic signed [63:0] m_q24;
    logic               m_last;
    logic [63:0]        d_try, d_rem_n;
    logic               d_ge;
    logic [DIV_W-1:0]   d_quo_n;
    logic               d_last;

    always_comb begin
        case (r_mcnt)
            2'd0:    m_chunk = r_mb[15:0];
            2'd1:    m_chunk = r_mb[31:16];
            default: m_chunk = r_mb[47:32];
        endcase
        m_part  = r_ma * m_chunk;
        m_sum   = r_acc + (96'(m_part) << {r_mcnt, 4'b0000});
        m_mag   = m_sum[87:24];
        m_q24   = r_neg ? $signed(-m_mag) : $signed(m_mag);
        m_last  = (r_mcnt == 2'd2);
        d_try   = {r_rem[62:0], r_dvd[DIV_W-1]};
        d_ge    = (d_try >= r_dvs);
        d_rem_n = d_ge ? d_try - r_dvs : d_try;
        d_quo_n = {r_quo[DIV_W-2:0], d_ge};
        d_last  = (r_dcnt == 6'(DIV_W - 1));
    end

    assign o_in_stall          = (r_state != ST_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_temperature_centi = r_out_temp;
    assign o_fault             = r_out_fault;
    assign o_average_code      = r_out_avg;

    // sequencer next state
    always_comb begin
        logic [SUM_W-1:0]    s;
        logic [SUM_W+AVG_SHIFT:0] avg_prod;
        logic [ADC_W-1:0]    avg;
        logic [31:0]         m_new;
        logic                sq_bit;
        logic signed [63:0]  lv, lq_n, inv;
        logic signed [48:0]  t;
        t_mul_op             op;

        n_state = r_state;   n_sum = r_sum;     n_count = r_count;
        n_avg = r_avg;       n_ma = r_ma;       n_mb = r_mb;
        n_acc = r_acc;       n_mcnt = r_mcnt;   n_neg = r_neg;
        n_m = r_m;           n_msb = r_msb;     n_lbit = r_lbit;
        n_frac = r_frac;     n_lsel = r_lsel;   n_lq = r_lq;
        n_lnr = r_lnr;       n_tmp = r_tmp;     n_p1 = r_p1;
        n_dvs = r_dvs;       n_rem = r_rem;     n_dvd = r_dvd;
        n_quo = r_quo;       n_dcnt = r_dcnt;   n_temp = r_temp;
        n_fault = r_fault;
        n_out_temp = r_out_temp; n_out_fault = r_out_fault; n_out_avg = r_out_avg;
        n_out_valid = r_out_valid && i_out_stall;

        s = r_sum + SUM_W'(i_adc_sample);
        avg_prod = s * AVG_RECIP;
        avg = avg_prod[AVG_SHIFT +: ADC_W];
        sq_bit = m_sum[63];
        m_new = sq_bit ? m_sum[63:32] : m_sum[62:31];
        lv = '0; lq_n = r_lq; inv = '0; t = '0;
        op = '0;

        // advance the multiplier by one 16-bit slice
        if (r_state inside {ST_NUM, ST_LSQ, ST_LNR, ST_SQ, ST_CUBE, ST_PB, ST_PC}) begin
            n_acc  = m_sum;
            n_mcnt = r_mcnt + 2'd1;
        end
        // advance the divider by one quotient bit
        if (r_state == ST_TDIV) begin
            n_rem  = d_rem_n;
            n_quo  = d_quo_n;
            n_dvd  = {r_dvd[DIV_W-2:0], 1'b0};
            n_dcnt = r_dcnt + 6'd1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if ({1'b0, r_count} + (CNT_W+1)'(1) < SAMPLES_W) begin
                        n_sum   = s;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_sum   = '0;
                        n_count = '0;
                        n_avg   = avg;
                        n_state = ST_AVG;
                    end
                end
            end
            ST_AVG: begin
                n_temp = '0;
                if (r_avg == '0 || r_avg == ADC_FULL || r_series == '0) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_fault = 1'b0;
                    n_ma    = 48'(r_series);
                    n_mb    = 48'(r_avg);
                    n_neg   = 1'b0;
                    n_acc   = '0;
                    n_mcnt  = '0;
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                if (m_last) begin
                    n_m     = m_sum[31:0];
                    n_msb   = 5'd31;
                    n_lsel  = 2'd0;
                    n_lq    = '0;
                    n_state = ST_LNORM;
                end
            end
            ST_LNORM: begin
                // shift up to the top bit, then start squaring
                if (r_m[31]) begin
                    n_ma    = 48'(r_m);
                    n_mb    = 48'(r_m);
                    n_neg   = 1'b0;
                    n_acc   = '0;
                    n_mcnt  = '0;
                    n_lbit  = 5'(LOG_FRAC - 1);
                    n_frac  = '0;
                    n_state = ST_LSQ;
                end else begin
                    n_m   = {r_m[30:0], 1'b0};
                    n_msb = r_msb - 5'd1;
                end
            end
            ST_LSQ: begin
                if (m_last) begin
                    n_frac = r_frac | (sq_bit ? (LOG_FRAC'(1) << r_lbit) : '0);
                    n_m    = m_new;
                    if (r_lbit == '0) begin
                        lv   = $signed(64'({r_msb, n_frac}));
                        lq_n = (r_lsel == 2'd0) ? r_lq + lv : r_lq - lv;
                        n_lq = lq_n;
                        case (r_lsel)
                            2'd0: begin
                                n_m     = 32'(ADC_FULL - r_avg);
                                n_msb   = 5'd31;
                                n_lsel  = 2'd1;
                                n_state = ST_LNORM;
                            end
                            2'd1: begin
                                n_m     = LOG_K;
                                n_msb   = 5'd31;
                                n_lsel  = 2'd2;
                                n_state = ST_LNORM;
                            end
                            default: begin
                                op      = mk_mul(lq_n, $signed(LN2_Q24));
                                n_ma    = op.ma;
                                n_mb    = op.mb;
                                n_neg   = op.neg;
                                n_acc   = '0;
                                n_mcnt  = '0;
                                n_state = ST_LNR;
                            end
                        endcase
                    end else begin
                        n_ma   = 48'(m_new);
                        n_mb   = 48'(m_new);
                        n_acc  = '0;
                        n_mcnt = '0;
                        n_lbit = r_lbit - 5'd1;
                    end
                end
            end
            ST_LNR: begin
                if (m_last) begin
                    n_lnr   = m_q24;
                    op      = mk_mul(m_q24, m_q24);
                    n_ma    = op.ma;  n_mb = op.mb;  n_neg = op.neg;
                    n_acc   = '0;     n_mcnt = '0;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                if (m_last) begin
                    op      = mk_mul(m_q24, r_lnr);
                    n_ma    = op.ma;  n_mb = op.mb;  n_neg = op.neg;
                    n_acc   = '0;     n_mcnt = '0;
                    n_state = ST_CUBE;
                end
            end
            ST_CUBE: begin
                if (m_last) begin
                    n_tmp   = m_q24;
                    op      = mk_mul(64'(signed'(r_coeff_b)), r_lnr);
                    n_ma    = op.ma;  n_mb = op.mb;  n_neg = op.neg;
                    n_acc   = '0;     n_mcnt = '0;
                    n_state = ST_PB;
                end
            end
            ST_PB: begin
                if (m_last) begin
                    n_p1    = m_q24;
                    op      = mk_mul(64'(signed'(r_coeff_c)), r_tmp);
                    n_ma    = op.ma;  n_mb = op.mb;  n_neg = op.neg;
                    n_acc   = '0;     n_mcnt = '0;
                    n_state = ST_PC;
                end
            end
            ST_PC: begin
                if (m_last) begin
                    inv = 64'(signed'(r_coeff_a)) + r_p1 + m_q24;
                    if (inv[63] || inv == '0) begin
                        n_fault = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_dvs   = 64'(inv);
                        n_dvd   = DIV_W'(100) << 40;
                        n_rem   = '0;
                        n_quo   = '0;
                        n_dcnt  = '0;
                        n_state = ST_TDIV;
                    end
                end
            end
            ST_TDIV: begin
                if (d_last) begin
                    t = $signed({2'b00, d_quo_n}) - $signed(KELVIN_CENTI);
                    if (t > 49'sd32767)
                        n_temp = 16'sh7fff;
                    else if (t < -49'sd32768)
                        n_temp = -16'sh8000;
                    else
                        n_temp = t[TEMP_W-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = r_temp;
                    n_out_fault = r_fault;
                    n_out_avg   = r_avg;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // hold state, configuration and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_series    <= SERIES_RST;
            r_coeff_a   <= COEF_A_RST;
            r_coeff_b   <= COEF_B_RST;
            r_coeff_c   <= COEF_C_RST;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SERIES:  r_series  <= i_cfg_data[SER_W-1:0];
                    CFG_COEFF_A: r_coeff_a <= i_cfg_data;
                    CFG_COEFF_B: r_coeff_b <= i_cfg_data;
                    CFG_COEFF_C: r_coeff_c <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_avg <= n_avg;   r_ma <= n_ma;     r_mb <= n_mb;
        r_acc <= n_acc;   r_mcnt <= n_mcnt; r_neg <= n_neg;
        r_m <= n_m;       r_msb <= n_msb;   r_lbit <= n_lbit;
        r_frac <= n_frac; r_lsel <= n_lsel; r_lq <= n_lq;
        r_lnr <= n_lnr;   r_tmp <= n_tmp;   r_p1 <= n_p1;
        r_dvs <= n_dvs;   r_rem <= n_rem;   r_dvd <= n_dvd;
        r_quo <= n_quo;   r_dcnt <= n_dcnt; r_temp <= n_temp;
        r_fault <= n_fault;
        r_out_temp <= n_out_temp;
        r_out_fault <= n_out_fault;
        r_out_avg <= n_out_avg;
    end

endmodule

// File: test/ntc_temperature_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC temperature checker
// Watches the sample, result and register ports of the thermistor core. It
// keeps its own window sum and register copy, computes each temperature
// result in fixed point and compares every delivered result in order.
// ----------------------------------------------------------------------------
module ntc_temperature_checker
    import ntc_avg_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [ADC_W-1:0]         i_adc_sample,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [TEMP_W-1:0] i_temperature_centi,
    input  logic                     i_fault,
    input  logic [ADC_W-1:0]         i_average_code,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [COEF_W-1:0]        i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_result_count
);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     fault;
        logic [ADC_W-1:0]         avg;
    } t_reading;

    t_reading                 reading_q[$];
    logic [SER_W-1:0]         series_r;
    logic signed [COEF_W-1:0] sh_a, sh_b, sh_c;
    logic [SUM_W-1:0]         win_sum;
    logic [CNT_W:0]           win_cnt;

    // x * y / 2^24, truncated toward zero
    function automatic logic signed [63:0] scale_mul(logic signed [63:0] x,
                                                     logic signed [63:0] y);
        logic        neg;
        logic [63:0] mx, my, r;
        neg = (x < 0) != (y < 0);
        mx  = x < 0 ? -x : x;
        my  = y < 0 ? -y : y;
        r   = (mx >> 24) * my + (((mx & 64'hFF_FFFF) * my) >> 24);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    // base-2 log in Q.24 by repeated squaring of the mantissa
    function automatic logic signed [63:0] log2_fix(logic [63:0] x);
        int          msb;
        logic [63:0] m, frac;
        msb  = 0;
        frac = '0;
        while (msb < 62 && (x >> (msb + 1)) != 0) msb++;
        m = x << (31 - msb);
        for (int i = LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(msb) << LOG_FRAC) | frac;
    endfunction

    function automatic t_reading convert_average(logic [ADC_W-1:0] avg);
        t_reading           rd;
        logic [63:0]        num, q;
        logic signed [63:0] lq, lnr, sq, cube, inv, t;
        rd.avg   = avg;
        rd.fault = 1'b0;
        rd.temp  = '0;
        num = 64'(avg) * 64'(series_r);
        if (avg == 0 || avg >= ADC_FULL || num == 0) begin
            rd.fault = 1'b1;
        end else begin
            lq   = log2_fix(num) - log2_fix(64'(ADC_FULL - avg)) - log2_fix(64'(LOG_K));
            lnr  = scale_mul(lq, $signed(LN2_Q24));
            sq   = scale_mul(lnr, lnr);
            cube = scale_mul(sq, lnr);
            inv  = 64'(sh_a) + scale_mul(64'(sh_b), lnr) + scale_mul(64'(sh_c), cube);
            if (inv <= 0) begin
                rd.fault = 1'b1;
            end else begin
                q = (64'd100 << 40) / $unsigned(inv);
                t = $signed(q) - 64'sd27315;
                if (t > 32767)  t = 32767;
                if (t < -32768) t = -32768;
                rd.temp = t[TEMP_W-1:0];
            end
        end
        return rd;
    endfunction

    // track registers and window, predict on window close, compare results
    always @(posedge i_clk) begin
        t_reading rd;
        if (!i_rst_n) begin
            series_r       = SERIES_RST;
            sh_a           = COEF_A_RST;
            sh_b           = COEF_B_RST;
            sh_c           = COEF_C_RST;
            win_sum        = '0;
            win_cnt        = '0;
            o_fail_count   = 0;
            o_result_count = 0;
            reading_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SERIES:  series_r = i_cfg_data[SER_W-1:0];
                    CFG_COEFF_A: sh_a = i_cfg_data;
                    CFG_COEFF_B: sh_b = i_cfg_data;
                    CFG_COEFF_C: sh_c = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                win_sum = win_sum + i_adc_sample;
                if (win_cnt + 1 < SAMPLES) begin
                    win_cnt = win_cnt + 1;
                end else begin
                    reading_q.push_back(convert_average(ADC_W'(win_sum / SAMPLES)));
                    win_sum = '0;
                    win_cnt = '0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (reading_q.size() == 0) begin
                    $error("unexpected result transaction: temperature_centi %0d",
                           i_temperature_centi);
                    o_fail_count++;
                end else begin
                    rd = reading_q.pop_front();
                    if (i_temperature_centi !== rd.temp) begin
                        $error("temperature_centi expected %0d actual %0d",
                               rd.temp, i_temperature_centi);
                        o_fail_count++;
                    end
                    if (i_fault !== rd.fault) begin
                        $error("fault expected %0d actual %0d", rd.fault, i_fault);
                        o_fail_count++;
                    end
                    if (i_average_code !== rd.avg) begin
                        $error("average_code expected %0d actual %0d",
                               rd.avg, i_average_code);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = reading_q.size();
    end

endmodule

// File: test/tb_ntc_average_steinhart_hart_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor core testbench
// Feeds sample windows under several register settings with random gaps and
// output stalls, including one long output hold-off; a checker predicts and
// compares every temperature result.
// ----------------------------------------------------------------------------
module tb_ntc_average_steinhart_hart_core;
    import ntc_avg_pkg::*;

    localparam int WIN       = SAMPLES_DEF;
    localparam int SETTLE    = 600;
    localparam int IDLE_MAX  = 20000;
    localparam int HOLD_LEN  = 1500;
    localparam logic [COEF_W-1:0] COEF_MIN = 48'h8000_0000_0000;
    localparam logic [COEF_W-1:0] COEF_MAX = 48'h7FFF_FFFF_FFFF;

    logic                     clk, rst_n;
    logic                     in_valid, in_stall;
    logic [ADC_W-1:0]         adc_sample;
    logic                     out_valid, out_stall;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic                     fault;
    logic [ADC_W-1:0]         average_code;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [COEF_W-1:0]        cfg_data;
    int                       fail_count, pending, result_count;
    int                       sample_total;
    int                       idle_cycles;
    bit                       hold_req, hold_done, fast_tx, fast_rx;

    ntc_average_steinhart_hart_core uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_adc_sample        (adc_sample),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_temperature_centi (temperature_centi),
        .o_fault             (fault),
        .o_average_code      (average_code),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    ntc_temperature_checker chk (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_adc_sample        (adc_sample),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_temperature_centi (temperature_centi),
        .i_fault             (fault),
        .i_average_code      (average_code),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_result_count      (result_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall per transaction, one long hold-off on request
    initial begin
        int gap;
        out_stall = 1'b1;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                gap = HOLD_LEN;
                hold_done = 1'b1;
            end else begin
                gap = fast_rx ? 0 : $urandom_range(0, 15);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [COEF_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_sample(logic [ADC_W-1:0] v);
        int gap;
        gap = fast_tx ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= v;
        do @(posedge clk); while (in_stall);
        sample_total++;
    endtask

    // constant window
    task automatic send_flat(logic [ADC_W-1:0] v);
        repeat (WIN) send_sample(v);
    endtask

    // window clustered around a random level, with some samples uniformly spread
    task automatic send_random_window();
        int center, spread, v;
        fast_tx = ($urandom_range(0, 3) == 0);
        fast_rx = ($urandom_range(0, 3) == 0);
        center  = $urandom_range(0, 1023);
        spread  = $urandom_range(0, 15);
        repeat (WIN) begin
            if ($urandom_range(0, 9) < 3) begin
                v = $urandom_range(0, 1023);
            end else begin
                v = center + $urandom_range(0, 2 * spread) - spread;
                if (v < 0)    v = 0;
                if (v > 1023) v = 1023;
            end
            send_sample(ADC_W'(v));
        end
    endtask

    // drain results and let the core go quiet before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic setup(logic [COEF_W-1:0] ser, logic [COEF_W-1:0] a,
                         logic [COEF_W-1:0] b, logic [COEF_W-1:0] c);
        settle();
        write_reg(CFG_SERIES, ser);
        write_reg(CFG_COEFF_A, a);
        write_reg(CFG_COEFF_B, b);
        write_reg(CFG_COEFF_C, c);
    endtask

    task automatic run_windows(int n);
        repeat (n) send_random_window();
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        return COEF_W'({$urandom(), $urandom()});
    endfunction

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        adc_sample   = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_SERIES;
        cfg_data     = '0;
        idle_cycles  = 0;
        sample_total = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        fast_tx      = 1'b0;
        fast_rx      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rails and mid-scale at the reset coefficients, then random windows
        send_flat(10'd0);
        send_flat(10'd1023);
        send_flat(10'd512);
        hold_req = 1'b1;
        run_windows(18);

        // series resistor of 1000000, upper data bits set to check masking
        setup(48'hFFFF_F00F_4240, COEF_A_RST, COEF_B_RST, COEF_C_RST);
        send_flat(10'd1);
        send_flat(10'd1022);
        run_windows(4);

        // zero series resistor faults every window
        setup(48'd0, COEF_A_RST, COEF_B_RST, COEF_C_RST);
        run_windows(1);

        setup(48'd1, COEF_A_RST, COEF_B_RST, COEF_C_RST);
        run_windows(5);

        // negative inverse temperature
        setup(48'd9700, COEF_MIN, 48'd0, 48'd0);
        run_windows(2);

        // huge inverse gives the coldest reading, tiny one saturates high
        setup(48'd9700, COEF_MAX, 48'd0, 48'd0);
        run_windows(2);
        setup(48'd9700, 48'd1, 48'd0, 48'd0);
        run_windows(2);

        setup(48'd9700, COEF_A_RST + ($urandom_range(0, 1 << 20) - (1 << 19)),
              rand_coef() >>> 16, rand_coef() >>> 24);
        run_windows(5);
        setup(48'($urandom_range(1, 1048575)), rand_coef(), COEF_MAX, COEF_MIN);
        run_windows(3);
        setup(48'($urandom_range(1, 1048575)), COEF_A_RST, COEF_B_RST, COEF_C_RST);
        run_windows(8);

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d samples over ten register settings, rails and faults.",
                 sample_total);
        $display("Checked %0d temperature results, with a long output hold-off.",
                 result_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
